// File: rtl/core/kvj_pkg.sv
// Shared types, constants and the CRC-32 byte step of the key-value journal.
package kvj_pkg;

   // Default geometry of the journal.
   localparam int ENTRIES_DEF       = 64;
   localparam int KEY_BYTES_DEF     = 16;
   localparam int PAYLOAD_BYTES_DEF = 32;

   // Reflected CRC-32.
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Most bytes a read ever returns.
   localparam logic [6:0] READ_CAP = 7'd32;

   // Command kinds.
   localparam logic [2:0] KIND_WRITE  = 3'd0;
   localparam logic [2:0] KIND_READ   = 3'd1;
   localparam logic [2:0] KIND_EXISTS = 3'd2;
   localparam logic [2:0] KIND_DELETE = 3'd3;
   localparam logic [2:0] KIND_FORMAT = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DISABLED  = 2'd1;
   localparam logic [1:0] ST_TOO_LONG  = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // Which stored data the scan pipeline consumes.
   typedef enum logic {
      PH_KEY,
      PH_CRC
   } phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       absorb;
      logic       acc_clear;
      logic       fmt;
      logic       copy_wr;
      logic       commit;
      logic       cnt_clear;
      logic       cnt_step;
      logic       scan_rd;
      phase_type  phase;
      logic       scan_init;
      logic       scan_next;
      logic       emit;
      logic [1:0] emit_status;
      logic       emit_byte;
      logic       emit_present;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] kind;
      logic       enabled;
      logic       over;
      logic       count_zero;
      logic       copy_done;
      logic       key_done;
      logic       crc_done;
      logic       pipe_busy;
      logic       key_match;
      logic       tomb;
      logic       crc_ok;
      logic       n_zero;
      logic       out_last;
      logic       s_zero;
      logic       out_busy;
   } sts_type;

   // One byte of the reflected CRC-32 update.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// File: rtl/core/kvj_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kvj_ram
   import kvj_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/kvj_ctrl.sv
// Command sequencer of the key-value journal.
module kvj_ctrl
   import kvj_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_tlast,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_COPY,
      S_SCAN_KEY,
      S_KEY_END,
      S_SCAN_CRC,
      S_CRC_END,
      S_OUT_RD,
      S_OUT_WAIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.phase = PH_KEY;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.absorb = 1'b1;
               if (req_tlast) begin
                  state_in = S_DISPATCH;
               end
            end
         end
         S_DISPATCH: begin
            if (!sts.out_busy) begin
               if (!sts.enabled) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_DISABLED;
                  cmd.acc_clear   = 1'b1;
                  state_in        = S_IDLE;
               end else if (sts.kind == KIND_WRITE && sts.over) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_TOO_LONG;
                  cmd.acc_clear   = 1'b1;
                  state_in        = S_IDLE;
               end else if (sts.kind == KIND_WRITE || sts.kind == KIND_DELETE) begin
                  cmd.cnt_clear = 1'b1;
                  state_in      = S_COPY;
               end else if (sts.kind == KIND_READ || sts.kind == KIND_EXISTS) begin
                  if (sts.count_zero) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = (sts.kind == KIND_READ) ? ST_NOT_FOUND : ST_OK;
                     cmd.acc_clear   = 1'b1;
                     state_in        = S_IDLE;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN_KEY;
                  end
               end else begin
                  // Format and the unused kinds answer ok at once.
                  cmd.fmt         = (sts.kind == KIND_FORMAT);
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_OK;
                  cmd.acc_clear   = 1'b1;
                  state_in        = S_IDLE;
               end
            end
         end
         S_COPY: begin
            cmd.copy_wr = 1'b1;
            if (!sts.copy_done) begin
               cmd.cnt_step = 1'b1;
            end else if (!sts.out_busy) begin
               cmd.commit      = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_OK;
               cmd.acc_clear   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_SCAN_KEY: begin
            cmd.phase = PH_KEY;
            if (!sts.key_done) begin
               cmd.scan_rd = 1'b1;
            end else if (!sts.pipe_busy) begin
               state_in = S_KEY_END;
            end
         end
         S_KEY_END: begin
            if (!sts.key_match) begin
               if (!sts.s_zero) begin
                  cmd.scan_next = 1'b1;
                  state_in      = S_SCAN_KEY;
               end else if (!sts.out_busy) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = (sts.kind == KIND_READ) ? ST_NOT_FOUND : ST_OK;
                  cmd.acc_clear   = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (sts.kind == KIND_EXISTS || sts.tomb) begin
               if (!sts.out_busy) begin
                  cmd.emit         = 1'b1;
                  cmd.emit_status  = (sts.kind == KIND_EXISTS) ? ST_OK : ST_NOT_FOUND;
                  cmd.emit_present = (sts.kind == KIND_EXISTS) && !sts.tomb;
                  cmd.acc_clear    = 1'b1;
                  state_in         = S_IDLE;
               end
            end else begin
               cmd.cnt_clear = 1'b1;
               state_in      = S_SCAN_CRC;
            end
         end
         S_SCAN_CRC: begin
            cmd.phase = PH_CRC;
            if (!sts.crc_done) begin
               cmd.scan_rd = 1'b1;
            end else if (!sts.pipe_busy) begin
               state_in = S_CRC_END;
            end
         end
         S_CRC_END: begin
            if (!sts.crc_ok) begin
               // A damaged record is skipped.
               if (!sts.s_zero) begin
                  cmd.scan_next = 1'b1;
                  state_in      = S_SCAN_KEY;
               end else if (!sts.out_busy) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_NOT_FOUND;
                  cmd.acc_clear   = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (sts.n_zero) begin
               if (!sts.out_busy) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_OK;
                  cmd.acc_clear   = 1'b1;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.cnt_clear = 1'b1;
               state_in      = S_OUT_RD;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (!sts.out_busy) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_OK;
               cmd.emit_byte   = 1'b1;
               cmd.cnt_step    = 1'b1;
               if (sts.out_last) begin
                  cmd.acc_clear = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/kvj_dpath.sv
// Datapath of the key-value journal: command gathering, stores, scan and result register.
module kvj_dpath
   import kvj_pkg::*;
#(
   parameter int ENTRIES       = ENTRIES_DEF,
   parameter int KEY_BYTES     = KEY_BYTES_DEF,
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [2:0]  req_kind,
   input  logic        req_part,
   input  logic        req_present,
   input  logic [7:0]  req_byte,
   input  logic [5:0]  req_limit,
   input  logic        csr_valid,
   input  logic        csr_data,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_byte,
   output logic        rsp_byte_valid,
   output logic [5:0]  rsp_length,
   output logic        rsp_present,
   output logic        rsp_last
);

   localparam int SW  = $clog2(ENTRIES);
   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int KA  = $clog2(ENTRIES * KEY_BYTES);
   localparam int PA  = $clog2(ENTRIES * PAYLOAD_BYTES);
   localparam int CP  = (KEY_BYTES > PAYLOAD_BYTES) ? KEY_BYTES : PAYLOAD_BYTES;
   localparam int JW  = $clog2(CP + 1);
   localparam int KIW = $clog2(KEY_BYTES);
   localparam int PIW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int LW  = $clog2(PAYLOAD_BYTES + 1);
   localparam int MW  = LW + 33;

   // Command gathering.
   logic [7:0]    lookup_ff [KEY_BYTES];
   logic [7:0]    lookup_in [KEY_BYTES];
   logic [7:0]    staged_ff [PAYLOAD_BYTES];
   logic [7:0]    staged_in [PAYLOAD_BYTES];
   logic [KIW-1:0] fill_ff, fill_in;
   logic          closed_ff, closed_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic          over_ff, over_in;
   logic [31:0]   run_crc_ff, run_crc_in;
   logic [2:0]    kind_ff, kind_in;
   logic [5:0]    limit_ff, limit_in;
   logic          enabled_ff, enabled_in;

   // Journal and scan state.
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] s_ff, s_in;
   logic [JW-1:0] j_ff, j_in;
   logic [JW-1:0] jd_ff, jd_in;
   logic          pend_ff, pend_in;
   logic          match_ff, match_in;
   logic [31:0]   scrc_ff, scrc_in;

   // Result register.
   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_status_ff, out_status_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_bvalid_ff, out_bvalid_in;
   logic [5:0]    out_length_ff, out_length_in;
   logic          out_present_ff, out_present_in;
   logic          out_last_ff, out_last_in;

   // Memory ports.
   logic [SW-1:0] slot;
   logic          key_wr_en, pay_wr_en;
   logic [KA-1:0] key_wr_addr, key_rd_addr;
   logic [PA-1:0] pay_wr_addr, pay_rd_addr;
   logic [7:0]    key_rd_data, pay_rd_data;
   logic [MW-1:0] meta_wr_data, meta_rd_data;
   logic          is_tomb;
   logic [LW-1:0] m_len;
   logic [31:0]   m_crc;
   logic          m_tomb;
   logic [6:0]    n_min, n_cnt;

   // Append slot: the newest slot is reused once the journal is full.
   assign slot = (count_ff >= CW'(ENTRIES)) ? SW'(ENTRIES - 1) : count_ff[SW-1:0];
   assign is_tomb = (kind_ff == KIND_DELETE);

   assign key_wr_en   = cmd.copy_wr && (j_ff < JW'(KEY_BYTES));
   assign pay_wr_en   = cmd.copy_wr && (j_ff < JW'(PAYLOAD_BYTES));
   assign key_wr_addr = KA'(slot) * KA'(KEY_BYTES) + KA'(j_ff);
   assign pay_wr_addr = PA'(slot) * PA'(PAYLOAD_BYTES) + PA'(j_ff);
   assign key_rd_addr = KA'(s_ff) * KA'(KEY_BYTES) + KA'(j_ff);
   assign pay_rd_addr = PA'(s_ff) * PA'(PAYLOAD_BYTES) + PA'(j_ff);
   assign meta_wr_data = {is_tomb,
                          is_tomb ? 32'd0 : ~run_crc_ff,
                          is_tomb ? LW'(0) : pos_ff};

   kvj_ram #(.WIDTH(8), .DEPTH(ENTRIES * KEY_BYTES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (lookup_ff[j_ff[KIW-1:0]]),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   kvj_ram #(.WIDTH(8), .DEPTH(ENTRIES * PAYLOAD_BYTES)) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (pay_wr_addr),
      .wr_data (staged_ff[j_ff[PIW-1:0]]),
      .rd_addr (pay_rd_addr),
      .rd_data (pay_rd_data)
   );

   kvj_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (slot),
      .wr_data (meta_wr_data),
      .rd_addr (s_ff),
      .rd_data (meta_rd_data)
   );

   assign m_len  = meta_rd_data[LW-1:0];
   assign m_crc  = meta_rd_data[LW+31:LW];
   assign m_tomb = meta_rd_data[MW-1];

   // Returned byte count: the least of stored length, limit and cap.
   assign n_min = (7'(m_len) < 7'(limit_ff)) ? 7'(m_len) : 7'(limit_ff);
   assign n_cnt = (n_min > READ_CAP) ? READ_CAP : n_min;

   // Status toward the controller.
   always_comb begin
      sts.kind       = kind_ff;
      sts.enabled    = enabled_ff;
      sts.over       = over_ff;
      sts.count_zero = (count_ff == '0);
      sts.copy_done  = (j_ff == JW'(CP - 1));
      sts.key_done   = (j_ff == JW'(KEY_BYTES));
      sts.crc_done   = (j_ff == JW'(m_len));
      sts.pipe_busy  = pend_ff;
      sts.key_match  = match_ff;
      sts.tomb       = m_tomb;
      sts.crc_ok     = (~scrc_ff == m_crc);
      sts.n_zero     = (n_cnt == 7'd0);
      sts.out_last   = (7'(j_ff) + 7'd1 == n_cnt);
      sts.s_zero     = (s_ff == '0);
      sts.out_busy   = out_valid_ff;
   end

   // Next values of the gathering, scan and result registers.
   always_comb begin
      lookup_in  = lookup_ff;
      staged_in  = staged_ff;
      fill_in    = fill_ff;
      closed_in  = closed_ff;
      pos_in     = pos_ff;
      over_in    = over_ff;
      run_crc_in = run_crc_ff;
      kind_in    = kind_ff;
      limit_in   = limit_ff;
      enabled_in = csr_valid ? csr_data : enabled_ff;
      count_in   = count_ff;
      s_in       = s_ff;
      j_in       = j_ff;
      jd_in      = j_ff;
      pend_in    = cmd.scan_rd;
      match_in   = match_ff;
      scrc_in    = scrc_ff;

      // Gather one request item.
      if (cmd.absorb) begin
         kind_in  = req_kind;
         limit_in = req_limit;
         if (req_present) begin
            if (!req_part) begin
               if (!closed_ff) begin
                  if (req_byte == 8'd0) begin
                     closed_in = 1'b1;
                  end else if (fill_ff < KIW'(KEY_BYTES - 1)) begin
                     lookup_in[fill_ff] = req_byte;
                     fill_in = fill_ff + KIW'(1);
                  end
               end
            end else if (pos_ff < LW'(PAYLOAD_BYTES)) begin
               staged_in[pos_ff[PIW-1:0]] = req_byte;
               pos_in     = pos_ff + LW'(1);
               run_crc_in = crc_byte(run_crc_ff, req_byte);
            end else begin
               over_in = 1'b1;
            end
         end
      end

      // Drop the gathered command once its final result is out.
      if (cmd.acc_clear) begin
         for (int k = 0; k < KEY_BYTES; k++) begin
            lookup_in[k] = 8'd0;
         end
         fill_in    = '0;
         closed_in  = 1'b0;
         pos_in     = '0;
         over_in    = 1'b0;
         run_crc_in = CRC_INIT;
      end

      if (cmd.fmt) begin
         count_in = '0;
      end
      if (cmd.commit) begin
         count_in = CW'(slot) + CW'(1);
      end

      // Byte counter shared by copy, scan and read-out.
      if (cmd.cnt_clear) begin
         j_in = '0;
      end else if (cmd.cnt_step || cmd.scan_rd) begin
         j_in = j_ff + JW'(1);
      end

      // Consume the byte read in the previous cycle.
      if (pend_ff) begin
         if (cmd.phase == PH_KEY) begin
            if (key_rd_data != lookup_ff[jd_ff[KIW-1:0]]) begin
               match_in = 1'b0;
            end
         end else begin
            scrc_in = crc_byte(scrc_ff, pay_rd_data);
         end
      end

      // Start on a record.
      if (cmd.scan_init || cmd.scan_next) begin
         s_in     = cmd.scan_init ? SW'(count_ff - CW'(1)) : s_ff - SW'(1);
         j_in     = '0;
         pend_in  = 1'b0;
         match_in = 1'b1;
         scrc_in  = CRC_INIT;
      end
   end

   // Result register in front of the response channel.
   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_status_in  = out_status_ff;
      out_byte_in    = out_byte_ff;
      out_bvalid_in  = out_bvalid_ff;
      out_length_in  = out_length_ff;
      out_present_in = out_present_ff;
      out_last_in    = out_last_ff;
      if (cmd.emit) begin
         out_valid_in   = 1'b1;
         out_status_in  = cmd.emit_status;
         out_byte_in    = cmd.emit_byte ? pay_rd_data : 8'd0;
         out_bvalid_in  = cmd.emit_byte;
         out_length_in  = cmd.emit_byte ? n_cnt[5:0] : 6'd0;
         out_present_in = cmd.emit_present;
         out_last_in    = cmd.emit_byte ? sts.out_last : 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff    <= 1'b0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         over_ff      <= 1'b0;
         run_crc_ff   <= CRC_INIT;
         enabled_ff   <= 1'b0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < KEY_BYTES; k++) begin
            lookup_ff[k] <= 8'd0;
         end
      end else begin
         closed_ff    <= closed_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         over_ff      <= over_in;
         run_crc_ff   <= run_crc_in;
         enabled_ff   <= enabled_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         lookup_ff    <= lookup_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      staged_ff      <= staged_in;
      kind_ff        <= kind_in;
      limit_ff       <= limit_in;
      s_ff           <= s_in;
      j_ff           <= j_in;
      jd_ff          <= jd_in;
      match_ff       <= match_in;
      scrc_ff        <= scrc_in;
      out_status_ff  <= out_status_in;
      out_byte_ff    <= out_byte_in;
      out_bvalid_ff  <= out_bvalid_in;
      out_length_ff  <= out_length_in;
      out_present_ff <= out_present_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_tvalid     = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_byte       = out_byte_ff;
   assign rsp_byte_valid = out_bvalid_ff;
   assign rsp_length     = out_length_ff;
   assign rsp_present    = out_present_ff;
   assign rsp_last       = out_last_ff;

   // A new result never lands on one still waiting.
   assert property (@(posedge clock) disable iff (reset) cmd.emit |-> !out_valid_ff)
      else $error("result register overwritten");

   // The record count stays within the journal.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(ENTRIES))
      else $error("record count beyond journal size");

   // Clearing the command leaves an empty payload behind.
   assert property (@(posedge clock) disable iff (reset)
                    cmd.acc_clear |=> (pos_ff == '0) && !over_ff)
      else $error("command not cleared");

endmodule

// File: rtl/core/crc_checked_key_value_journal.sv
// Top level of the CRC-checked append-only key-value journal.
//
//  channel | direction | contents
//  req_    | in        | tdata: data_byte, read_limit; tuser: kind, part, byte_present; tlast
//  rsp_    | out       | tdata: status, read_byte, length, key_present; tuser: byte valid
//  csr_    | in        | data: journal_enabled
//
// A command item is taken while idle. A write or delete then passes through dispatch and
// copies max(KEY_BYTES, PAYLOAD_BYTES) bytes into the stores, one per cycle. A read or
// exists scans records newest first, comparing key bytes and deciding at the key end; a
// read then rechecks the CRC over the stored length and returns each byte through a read
// and a wait state. Reset clears the record count and control registers, not the stores;
// no clearing pass is needed. A stalled response holds the sequencer at its next result.
module crc_checked_key_value_journal
   import kvj_pkg::*;
#(
   parameter int ENTRIES       = ENTRIES_DEF,
   parameter int KEY_BYTES     = KEY_BYTES_DEF,
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], read_limit[13:8], zero
   input  logic [4:0]  req_tuser,   // kind[2:0], part[3], byte_present[4]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[1:0], read_byte[9:2], length[15:10],
                                    // key_present[16], zero
   output logic        rsp_tuser,   // read_byte_valid
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   cmd_type    cmd;
   sts_type    sts;
   logic [1:0] rsp_status;
   logic [7:0] rsp_byte;
   logic [5:0] rsp_length;
   logic       rsp_present;

   assign csr_ready = 1'b1;

   kvj_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kvj_dpath #(
      .ENTRIES       (ENTRIES),
      .KEY_BYTES     (KEY_BYTES),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_tuser[2:0]),
      .req_part       (req_tuser[3]),
      .req_present    (req_tuser[4]),
      .req_byte       (req_tdata[7:0]),
      .req_limit      (req_tdata[13:8]),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_status     (rsp_status),
      .rsp_byte       (rsp_byte),
      .rsp_byte_valid (rsp_tuser),
      .rsp_length     (rsp_length),
      .rsp_present    (rsp_present),
      .rsp_last       (rsp_tlast)
   );

   // Pack the response fields.
   assign rsp_tdata = {7'd0, rsp_present, rsp_length, rsp_byte, rsp_status};

endmodule
